FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared codes and control types for the sorted priority queue core
// ----------------------------------------------------------------------------
package spq_pkg;

    // command codes of an input word
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_PULL   = 1'b1;

    // status codes of an output word
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PULL_EMPTY = 2'd1;
    localparam logic [1:0] ST_INSERT_FULL = 2'd2;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic insert_en;
        logic pull_en;
    } t_spq_ctrl;

endpackage

FILE: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, takes the new entry or shifts
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                             i_clk,
    input  t_spq_ctrl                        i_ctrl,
    input  logic                             i_occ,
    input  logic                             i_left_ge,
    input  logic [VALUE_WIDTH-1:0]           i_left_value,
    input  logic signed [PRIORITY_WIDTH-1:0] i_left_prio,
    input  logic [VALUE_WIDTH-1:0]           i_right_value,
    input  logic signed [PRIORITY_WIDTH-1:0] i_right_prio,
    input  logic [VALUE_WIDTH-1:0]           i_new_value,
    input  logic signed [PRIORITY_WIDTH-1:0] i_new_prio,
    output logic                             o_ge,
    output logic [VALUE_WIDTH-1:0]           o_value,
    output logic signed [PRIORITY_WIDTH-1:0] o_prio
);

    logic [VALUE_WIDTH-1:0]           r_value;
    logic signed [PRIORITY_WIDTH-1:0] r_prio;
    logic [VALUE_WIDTH-1:0]           n_value;
    logic signed [PRIORITY_WIDTH-1:0] n_prio;

    // occupied and ranked at or above the new entry: stays put
    assign o_ge    = i_occ && (r_prio >= i_new_prio);
    assign o_value = r_value;
    assign o_prio  = r_prio;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctrl.insert_en) begin
            if (!o_ge) begin
                if (i_left_ge) begin
                    n_value = i_new_value;
                    n_prio  = i_new_prio;
                end else begin
                    n_value = i_left_value;
                    n_prio  = i_left_prio;
                end
            end
        end else if (i_ctrl.pull_en) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule

FILE: rtl/core/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// bounded priority queue held as a sorted chain of cells, head in cell 0
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+---------------------------------------
//  input   | i_in_valid  | o_in_stall   | i_command, i_value_in, i_priority_in
//  output  | o_out_valid | i_out_stall  | o_pulled_value, o_head_value,
//          |             |              | o_is_empty, o_entry_count, o_status
//
//  one word per cycle while the input is not stalled: every cell decides keep /
//  take new / shift in parallel, so the whole chain updates together and the
//  result word is registered; it is valid in the cycle after input accept.
//  the input stalls only while a finished output word waits and is stalled.
//  i_rst_n (synchronous, active low) empties the queue and the output stage;
//  cell contents are not cleared, only slots below the count are ever read.
//
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    localparam int CNT_W         = $clog2(CAPACITY + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_command,
    input  logic [VALUE_WIDTH-1:0]           i_value_in,
    input  logic signed [PRIORITY_WIDTH-1:0] i_priority_in,
    // output words
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [VALUE_WIDTH-1:0]           o_pulled_value,
    output logic [VALUE_WIDTH-1:0]           o_head_value,
    output logic                             o_is_empty,
    output logic [CNT_W-1:0]                 o_entry_count,
    output logic [1:0]                       o_status
);

    // chain wiring between neighbor cells
    logic                             w_ge    [CAPACITY];
    logic [VALUE_WIDTH-1:0]           w_value [CAPACITY];
    logic signed [PRIORITY_WIDTH-1:0] w_prio  [CAPACITY];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_spq_ctrl        w_ctrl;

    // output stage
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_pulled;
    logic [VALUE_WIDTH-1:0] r_head;
    logic [CNT_W-1:0]       r_out_count;
    logic [1:0]             r_status;
    logic [VALUE_WIDTH-1:0] n_pulled;
    logic [VALUE_WIDTH-1:0] n_head;
    logic [1:0]             n_status;

    // accept whenever the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_ctrl.insert_en = w_accept && (i_command == CMD_INSERT) && !w_full;
    assign w_ctrl.pull_en   = w_accept && (i_command == CMD_PULL) && !w_empty;

    // the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                             w_left_ge;
        logic [VALUE_WIDTH-1:0]           w_left_value;
        logic signed [PRIORITY_WIDTH-1:0] w_left_prio;
        logic [VALUE_WIDTH-1:0]           w_right_value;
        logic signed [PRIORITY_WIDTH-1:0] w_right_prio;

        if (g == 0) begin : g_first
            // head cell: nothing to its left, so it takes the new entry directly
            assign w_left_ge    = 1'b1;
            assign w_left_value = i_value_in;
            assign w_left_prio  = i_priority_in;
        end else begin : g_mid
            assign w_left_ge    = w_ge[g-1];
            assign w_left_value = w_value[g-1];
            assign w_left_prio  = w_prio[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // tail cell empties on a pull, its contents no longer matter
            assign w_right_value = w_value[g];
            assign w_right_prio  = w_prio[g];
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_prio  = w_prio[g+1];
        end

        spq_cell #(
            .VALUE_WIDTH    (VALUE_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occ         (CNT_W'(g) < r_count),
            .i_left_ge     (w_left_ge),
            .i_left_value  (w_left_value),
            .i_left_prio   (w_left_prio),
            .i_right_value (w_right_value),
            .i_right_prio  (w_right_prio),
            .i_new_value   (i_value_in),
            .i_new_prio    (i_priority_in),
            .o_ge          (w_ge[g]),
            .o_value       (w_value[g]),
            .o_prio        (w_prio[g])
        );
    end

    // count and result word for the accepted input
    always_comb begin
        n_count  = r_count;
        n_pulled = '0;
        n_status = ST_OK;
        if (w_ctrl.insert_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pull_en) begin
            n_count  = r_count - CNT_W'(1);
            n_pulled = w_value[0];
        end else if (i_command == CMD_PULL) begin
            n_status = ST_PULL_EMPTY;
        end else begin
            n_status = ST_INSERT_FULL;
        end
    end

    // head after the step, taken from what cell 0 is about to hold
    always_comb begin
        n_head = w_value[0];
        if (n_count == '0) begin
            n_head = '0;
        end else if (w_ctrl.insert_en && !w_ge[0]) begin
            n_head = i_value_in;
        end else if (w_ctrl.pull_en) begin
            n_head = w_value[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pulled    <= n_pulled;
            r_head      <= n_head;
            r_out_count <= n_count;
            r_status    <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulled_value = r_pulled;
    assign o_head_value   = r_head;
    assign o_is_empty     = (r_out_count == '0);
    assign o_entry_count  = r_out_count;
    assign o_status       = r_status;

endmodule

FILE: rtl/core/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks on the sorted priority queue core
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int CNT_W          = $clog2(CAPACITY + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic                             i_command,
    input  logic [VALUE_WIDTH-1:0]           i_value_in,
    input  logic signed [PRIORITY_WIDTH-1:0] i_priority_in,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic [VALUE_WIDTH-1:0]           o_pulled_value,
    input  logic [VALUE_WIDTH-1:0]           o_head_value,
    input  logic                             o_is_empty,
    input  logic [CNT_W-1:0]                 o_entry_count,
    input  logic [1:0]                       o_status
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_entry_count)
            && $stable(o_head_value) && $stable(o_status))
        else $error("stalled output word changed");

    // an accepted word always yields a result word next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted word gave no result");

    // count never exceeds capacity and empty flag tracks it
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= CNT_W'(CAPACITY))
            && (o_is_empty == (o_entry_count == '0)))
        else $error("entry count out of range");

    // empty queue reports zero head, failed steps pull nothing
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_is_empty || o_status != ST_OK)
            |-> (o_pulled_value == '0 || o_status == ST_OK)
            && (o_head_value == '0 || !o_is_empty))
        else $error("nonzero value on empty or failed step");

    // a refused insert only happens at full capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_INSERT_FULL |-> o_entry_count == CNT_W'(CAPACITY))
        else $error("insert refused below capacity");

endmodule

bind sorted_priority_queue_core spq_checker #(
    .CAPACITY       (CAPACITY),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .CNT_W          (CNT_W)
) u_spq_checker (.*);
